// ----- hdl/ldrt_pkg.sv -----
package ldrt_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int VALUE_W      = 32;
   localparam int RUN_W        = 9;
   localparam int RUN_MAX      = (1 << RUN_W) - 1;
   localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W        = (LEN_W > RUN_W) ? LEN_W : RUN_W;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } ldrt_req_type;

   typedef struct packed {
      logic [RUN_W-1:0] longest_run;
      logic             overflow;
   } ldrt_rsp_type;

   // broadcast from control to every cell
   typedef struct packed {
      logic               capture;
      logic               shift;
      logic [VALUE_W-1:0] probe;
      logic [VALUE_W-1:0] entry;
   } ldrt_cell_cmd_type;

endpackage

// ----- hdl/ldrt_cell.sv -----
module ldrt_cell
   import ldrt_pkg::*;
(
   input  logic                  clock,
   input  ldrt_cell_cmd_type     cmd,
   input  logic                  live,
   input  logic [VALUE_W-1:0]    shift_in,
   output logic [VALUE_W-1:0]    value_out,
   output logic                  match
);

   logic [VALUE_W-1:0] value_ff;
   logic               match_ff;
   logic               match_in;

   assign match_in = live && (value_ff == cmd.probe);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         match_ff <= match_in;
      end
      if (cmd.shift) begin
         value_ff <= shift_in;
      end
   end

   assign value_out = value_ff;
   assign match     = match_ff;

endmodule

// ----- hdl/ldrt_ctrl.sv -----
module ldrt_ctrl
   import ldrt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ldrt_req_type             req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ldrt_rsp_type             rsp_word,
   input  logic [WINDOW_DEPTH-1:0]  hit,
   output ldrt_cell_cmd_type        cell_cmd,
   output logic [LEN_W-1:0]         win_len
);

   logic               busy_ff;
   logic               last_ff;
   logic [VALUE_W-1:0] entry_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic [RUN_W-1:0]   best_ff;
   logic [RUN_W-1:0]   best_in;
   logic               ovf_ff;
   logic               ovf_in;
   logic               rsp_valid_ff;
   ldrt_rsp_type       rsp_word_ff;

   logic               accept;
   logic               any_hit;
   logic [IDX_W-1:0]   hit_idx;
   logic               full;
   logic [RUN_W-1:0]   run_len;

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready || !req_word.last);
   assign accept    = req_valid && req_ready;

   // at most one cell matches, so an OR of indexes encodes it
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (hit[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign any_hit = |hit;
   assign full    = (len_ff == LEN_W'(WINDOW_DEPTH));

   always_comb begin
      if (any_hit) begin
         len_in = LEN_W'(hit_idx) + LEN_W'(1);
      end else if (full) begin
         len_in = len_ff;
      end else begin
         len_in = len_ff + LEN_W'(1);
      end
      ovf_in = ovf_ff || (!any_hit && full);
      if (CMP_W'(len_in) > CMP_W'(RUN_MAX)) begin
         run_len = RUN_W'(RUN_MAX);
      end else begin
         run_len = RUN_W'(len_in);
      end
      best_in = (run_len > best_ff) ? run_len : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         len_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (busy_ff) begin
            busy_ff <= 1'b0;
            if (last_ff) begin
               len_ff       <= '0;
               best_ff      <= '0;
               ovf_ff       <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end else begin
               len_ff  <= len_in;
               best_ff <= best_in;
               ovf_ff  <= ovf_in;
            end
         end else if (accept) begin
            busy_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= req_word.value;
         last_ff  <= req_word.last;
      end
      if (busy_ff && last_ff) begin
         rsp_word_ff.longest_run <= best_in;
         rsp_word_ff.overflow    <= ovf_in;
      end
   end

   assign cell_cmd.capture = accept;
   assign cell_cmd.shift   = busy_ff;
   assign cell_cmd.probe   = req_word.value;
   assign cell_cmd.entry   = entry_ff;

   assign win_len   = len_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hdl/longest_distinct_run_tracker_unit.sv -----
// channel   dir  handshake             word
// req       in   req_valid/req_ready   value[31:0], last
// rsp       out  rsp_valid/rsp_ready   longest_run[8:0], overflow
//
// Per word, the accept edge registers every cell's compare against the
// incoming value; the next edge shifts the cell chain and updates the run
// length, best length and overflow flag. A result is produced on a last word.
// Reset is synchronous and empties the window.
// req_ready is low in the shift cycle after every accept; a last word is also
// held off while an earlier result is still waiting.
module longest_distinct_run_tracker_unit
   import ldrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ldrt_req_type  req_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ldrt_rsp_type  rsp_word
);

   ldrt_cell_cmd_type        cell_cmd;
   logic [LEN_W-1:0]         win_len;
   logic [WINDOW_DEPTH-1:0]  hit;
   logic [VALUE_W-1:0]       chain [WINDOW_DEPTH+1];

   assign chain[0] = cell_cmd.entry;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic live;
      assign live = (win_len > LEN_W'(i));

      ldrt_cell u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .live      (live),
         .shift_in  (chain[i]),
         .value_out (chain[i+1]),
         .match     (hit[i])
      );
   end

   ldrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .hit       (hit),
      .cell_cmd  (cell_cmd),
      .win_len   (win_len)
   );

endmodule

// ----- test/ldrt_run_checker.sv -----
`timescale 1ns / 100ps

module ldrt_run_checker
   import ldrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  ldrt_req_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  ldrt_rsp_type rsp_word,
   output int           error_count,
   output int           runs_pending
);

   // newest value at index 0
   logic [VALUE_W-1:0] window_q[$];
   logic [RUN_W-1:0]   best_run;
   logic               wrapped;
   ldrt_rsp_type       expected_runs[$];
   int                 errors = 0;

   task automatic clear_window();
      window_q.delete();
      best_run = '0;
      wrapped  = 1'b0;
   endtask

   task automatic absorb_word(input ldrt_req_type w);
      int hit;
      int span;
      ldrt_rsp_type run_word;
      hit = -1;
      foreach (window_q[i]) begin
         if (hit < 0 && window_q[i] == w.value) hit = i;
      end
      if (hit >= 0) begin
         while (window_q.size() > hit) void'(window_q.pop_back());
      end else if (window_q.size() == WINDOW_DEPTH) begin
         wrapped = 1'b1;
         void'(window_q.pop_back());
      end
      window_q.push_front(w.value);
      span = window_q.size();
      if (span > RUN_MAX) span = RUN_MAX;
      if (span > best_run) best_run = span[RUN_W-1:0];
      if (w.last) begin
         run_word = ldrt_rsp_type'{longest_run: best_run, overflow: wrapped};
         expected_runs.insert(expected_runs.size(), run_word);
         clear_window();
      end
   endtask

   always @(posedge clock) begin
      ldrt_rsp_type want;
      if (reset) begin
         clear_window();
         expected_runs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected word: longest_run %0d overflow %0b",
                      rsp_word.longest_run, rsp_word.overflow);
               errors++;
            end else begin
               want = expected_runs.pop_front();
               if (rsp_word.longest_run !== want.longest_run) begin
                  $error("longest_run: expected %0d, got %0d",
                         want.longest_run, rsp_word.longest_run);
                  errors++;
               end
               if (rsp_word.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b",
                         want.overflow, rsp_word.overflow);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) absorb_word(req_word);
      end
      error_count  <= errors;
      runs_pending <= expected_runs.size();
   end

endmodule

// ----- test/longest_distinct_run_tracker_unit_tb.sv -----
`timescale 1ns / 100ps

module longest_distinct_run_tracker_unit_tb;
   import ldrt_pkg::*;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   ldrt_req_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   ldrt_rsp_type rsp_word;
   int           fail_count;
   int           runs_pending;

   int           words_sent = 0;
   bit           idle_on = 1'b1;

   always #5 clock = ~clock;

   longest_distinct_run_tracker_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   ldrt_run_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .error_count  (fail_count),
      .runs_pending (runs_pending)
   );

   task automatic send_word(input logic [VALUE_W-1:0] v, input logic l);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= ldrt_req_type'{value: v, last: l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // alphabet 0: all distinct, negative: fully random, else drawn from that many values
   task automatic send_case(input int n, input int alphabet);
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] v;
      int k;
      base = $urandom;
      for (k = 0; k < n; k++) begin
         if (alphabet == 0) v = base + k;
         else if (alphabet < 0) v = $urandom;
         else v = base + $urandom_range(0, alphabet - 1);
         send_word(v, k == n - 1);
      end
   endtask

   initial begin
      logic [VALUE_W-1:0] base;
      int k;
      int pick;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-word cases, field extremes, repeats
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0000_0005, 1'b0);
      send_word(32'h0000_0005, 1'b0);
      send_word(32'h0000_0005, 1'b1);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0002, 1'b0);
      send_word(32'h0000_0003, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0004, 1'b1);
      send_word(32'hAAAA_AAAA, 1'b0);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b0);
      send_word(32'h5555_5555, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0000, 1'b1);

      // window exactly full, no overflow
      send_case(WINDOW_DEPTH, 0);
      // window full, then a repeat of the oldest value
      base = $urandom;
      for (k = 0; k < WINDOW_DEPTH; k++) send_word(base + k, 1'b0);
      send_word(base, 1'b1);
      // window runs past its depth
      send_case(WINDOW_DEPTH + 40, 0);

      while (words_sent < 1950) begin
         if (words_sent >= 1700) idle_on = 1'b0;
         pick = $urandom_range(0, 39);
         if (pick == 0) send_case($urandom_range(250, 270), 0);
         else if (pick < 4) send_case($urandom_range(1, 30), -1);
         else if (pick < 8) send_case($urandom_range(20, 120), $urandom_range(20, 300));
         else send_case($urandom_range(1, 40), $urandom_range(1, 24));
      end
      req_valid <= 1'b0;

      while (runs_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && runs_pending == 0) begin
         $display("longest_distinct_run_tracker_unit_tb: done, clean");
      end else begin
         $display("longest_distinct_run_tracker_unit_tb: done, errors");
      end
      $finish;
   end

   // receiver: random stalls plus one long hold-off so last words back up
   initial begin
      int n;
      bit held;
      int gap;
      held      = 1'b0;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && words_sent >= 1000) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            for (n = 0; n < 300; n++) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("longest_distinct_run_tracker_unit_tb: done, errors");
      $finish;
   end

endmodule
